/* design/deq_pkg.sv */
// Shared types and constants for the double-ended queue.
`default_nettype none
package deq_pkg;

	localparam int DEPTH   = 16;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int WORD_W  = 32;
	localparam int COUNT_W = 5;

	localparam logic [1:0] FN_PUSH_FRONT = 2'd0;
	localparam logic [1:0] FN_PUSH_REAR  = 2'd1;
	localparam logic [1:0] FN_POP_FRONT  = 2'd2;
	localparam logic [1:0] FN_POP_REAR   = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam logic signed [WORD_W-1:0] ALL_ONES = '1;

	typedef struct packed {
		logic [1:0]               func;
		logic signed [WORD_W-1:0] push_value;
	} req_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] popped_value;
		logic [1:0]               status;
		logic [COUNT_W-1:0]       count;
		logic signed [WORD_W-1:0] front_value;
		logic signed [WORD_W-1:0] rear_value;
	} rsp_t;

	typedef struct packed {
		logic load_req;
		logic exec;
		logic load_peek;
		logic load_out;
	} cmd_t;

endpackage
`default_nettype wire

/* design/double_ended_queue_unit.sv */
// Double-ended queue over a ring store: top level with controller and datapath.
// A request beat is registered and executed; after a pop the registered read
// of the single ring read port refreshes the front or rear peek. The result
// is loaded once that slot is free; only then is a new request taken. The
// result register lets the next request enter while a result waits.
// Reset (arst_n low) empties the deque; ring contents stay undefined.
`default_nettype none
module double_ended_queue_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire deq_pkg::req_t in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output deq_pkg::rsp_t      out_data
);
	import deq_pkg::*;

	cmd_t cmd;

	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	deq_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (in_data),
		.out_data (out_data)
	);

	a_exec_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_req |=> cmd.exec)
		else $error("execute did not follow request beat");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid || out_ready))
		else $error("pending result overwritten");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.count <= COUNT_W'(DEPTH)))
		else $error("count beyond depth");

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec || cmd.load_peek) |-> !in_ready)
		else $error("request accepted while busy");

endmodule
`default_nettype wire

/* design/deq_ctrl.sv */
// Sequencer for the double-ended queue: accept, execute, peek refresh, result.
`default_nettype none
module deq_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	output deq_pkg::cmd_t      cmd
);
	import deq_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_PEEK,
		S_DONE
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   out_valid_q;

	always_comb begin
		cmd.load_req  = in_valid && in_ready_q;
		cmd.exec      = (state_q == S_EXEC);
		cmd.load_peek = (state_q == S_PEEK);
		cmd.load_out  = (state_q == S_DONE) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.load_req) begin
						state_q    <= S_EXEC;
						in_ready_q <= 1'b0;
					end
				end
				S_EXEC: state_q <= S_PEEK;
				S_PEEK: state_q <= S_DONE;
				S_DONE: begin
					// hold until the result slot frees up
					if (cmd.load_out) begin
						state_q    <= S_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

/* design/deq_dp.sv */
// Ring store, pointers, count, cached peeks and result register.
`default_nettype none
module deq_dp (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire deq_pkg::cmd_t cmd,
	input  wire deq_pkg::req_t in_data,
	output deq_pkg::rsp_t      out_data
);
	import deq_pkg::*;

	function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
		return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
	endfunction

	logic signed [WORD_W-1:0] ring_mem [DEPTH];

	req_t                     req_q;
	logic [IDX_W-1:0]         head_q;
	logic [IDX_W-1:0]         tail_q;
	logic [CNT_W-1:0]         cnt_q;
	logic signed [WORD_W-1:0] front_q;
	logic signed [WORD_W-1:0] rear_q;
	logic signed [WORD_W-1:0] popped_q;
	logic [1:0]               status_q;
	logic signed [WORD_W-1:0] rd_q;
	logic                     peek_front_q;
	logic                     peek_rear_q;
	rsp_t                     rsp_q;

	logic                     full;
	logic                     empty;
	logic                     wr_en;
	logic [IDX_W-1:0]         wr_addr;
	logic [IDX_W-1:0]         rd_addr;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = tail_q;
		if (cmd.exec && !full) begin
			if (req_q.func == FN_PUSH_FRONT) begin
				wr_en   = 1'b1;
				wr_addr = ring_prev(head_q);
			end else if (req_q.func == FN_PUSH_REAR) begin
				wr_en = 1'b1;
			end
		end
	end

	// address of the new front or rear once the pop has moved the pointer
	assign rd_addr = (req_q.func == FN_POP_FRONT) ? ring_next(head_q)
	                                              : ring_prev(ring_prev(tail_q));

	always_ff @(posedge clk) begin
		if (wr_en)
			ring_mem[wr_addr] <= req_q.push_value;
		rd_q <= ring_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			tail_q       <= '0;
			cnt_q        <= '0;
			peek_front_q <= 1'b0;
			peek_rear_q  <= 1'b0;
		end else begin
			if (cmd.load_req) begin
				peek_front_q <= 1'b0;
				peek_rear_q  <= 1'b0;
			end
			if (cmd.exec) begin
				case (req_q.func)
					FN_PUSH_FRONT: begin
						if (!full) begin
							head_q <= ring_prev(head_q);
							cnt_q  <= cnt_q + 1'b1;
						end
					end
					FN_PUSH_REAR: begin
						if (!full) begin
							tail_q <= ring_next(tail_q);
							cnt_q  <= cnt_q + 1'b1;
						end
					end
					FN_POP_FRONT: begin
						if (!empty) begin
							head_q       <= ring_next(head_q);
							cnt_q        <= cnt_q - 1'b1;
							peek_front_q <= 1'b1;
						end
					end
					default: begin
						if (!empty) begin
							tail_q      <= ring_prev(tail_q);
							cnt_q       <= cnt_q - 1'b1;
							peek_rear_q <= 1'b1;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req)
			req_q <= in_data;
		if (cmd.exec) begin
			popped_q <= ALL_ONES;
			status_q <= ST_OK;
			case (req_q.func) inside
				FN_PUSH_FRONT, FN_PUSH_REAR: begin
					if (full) begin
						status_q <= ST_FULL;
					end else begin
						if (req_q.func == FN_PUSH_FRONT || empty)
							front_q <= req_q.push_value;
						if (req_q.func == FN_PUSH_REAR || empty)
							rear_q <= req_q.push_value;
					end
				end
				default: begin
					if (empty)
						status_q <= ST_EMPTY;
					else if (req_q.func == FN_POP_FRONT)
						popped_q <= front_q;
					else
						popped_q <= rear_q;
				end
			endcase
		end
		// refresh the peek that the pop moved
		if (cmd.load_peek) begin
			if (peek_front_q)
				front_q <= rd_q;
			if (peek_rear_q)
				rear_q <= rd_q;
		end
		if (cmd.load_out) begin
			rsp_q.popped_value <= popped_q;
			rsp_q.status       <= status_q;
			rsp_q.count        <= COUNT_W'(cnt_q);
			rsp_q.front_value  <= empty ? ALL_ONES : front_q;
			rsp_q.rear_value   <= empty ? ALL_ONES : rear_q;
		end
	end

	assign out_data = rsp_q;

endmodule
`default_nettype wire

/* sim/double_ended_queue_unit_test.sv */
// Self-checking testbench for the double-ended queue unit: directed and random beats.
module double_ended_queue_unit_test;
	import deq_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int TAIL_ITEMS   = 120;
	localparam int RANDOM_ITEMS = 1426;
	localparam int LONG_HOLD    = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	req_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rsp_t out_data;

	req_t pending_reqs[$];
	rsp_t expected_results[$];
	int error_count = 0;

	// shadow deque
	logic signed [WORD_W-1:0] deque_words[DEPTH];
	int front_slot = 0;
	int rear_next = 0;
	int held_count = 0;

	double_ended_queue_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic rsp_t deque_result(req_t r);
		rsp_t res;
		res.popped_value = ALL_ONES;
		res.status = ST_OK;
		res.front_value = ALL_ONES;
		res.rear_value = ALL_ONES;
		if (r.func == FN_PUSH_FRONT || r.func == FN_PUSH_REAR) begin
			if (held_count == DEPTH) begin
				res.status = ST_FULL;
			end else if (r.func == FN_PUSH_FRONT) begin
				front_slot = (front_slot + DEPTH - 1) % DEPTH;
				deque_words[front_slot] = r.push_value;
				held_count++;
			end else begin
				deque_words[rear_next] = r.push_value;
				rear_next = (rear_next + 1) % DEPTH;
				held_count++;
			end
		end else if (held_count == 0) begin
			res.status = ST_EMPTY;
		end else if (r.func == FN_POP_FRONT) begin
			res.popped_value = deque_words[front_slot];
			front_slot = (front_slot + 1) % DEPTH;
			held_count--;
		end else begin
			rear_next = (rear_next + DEPTH - 1) % DEPTH;
			res.popped_value = deque_words[rear_next];
			held_count--;
		end
		res.count = COUNT_W'(held_count);
		if (held_count != 0) begin
			res.front_value = deque_words[front_slot];
			res.rear_value = deque_words[(rear_next + DEPTH - 1) % DEPTH];
		end
		return res;
	endfunction

	function automatic logic [WORD_W-1:0] pick_word();
		logic [WORD_W-1:0] w;
		w = $urandom;
		// lean on the corner words now and then
		if ($urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 3))
				0: w = '0;
				1: w = '1;
				2: w = 32'h8000_0000;
				default: w = 32'h7FFF_FFFF;
			endcase
		end
		return w;
	endfunction

	task automatic queue_req(logic [1:0] fn, logic [WORD_W-1:0] word);
		req_t r;
		r.func = fn;
		r.push_value = word;
		pending_reqs.push_back(r);
	endtask

	task automatic check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			error_count++;
		end
	endtask

	// sender
	int gap_left = 0;
	int send_rate = 0;
	logic [6:0] send_window = '0;

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
			send_window <= '0;
		end else begin
			send_window <= send_window + 1'b1;
			if (send_window == '0)
				send_rate <= $urandom_range(0, 3);
			if (in_valid && in_ready)
				expected_results.push_back(deque_result(in_data));
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() == 0) begin
					in_valid <= 1'b0;
				end else if (pending_reqs.size() > TAIL_ITEMS && send_rate != 0 &&
						$urandom_range(0, 15) < send_rate) begin
					// idle burst
					gap_left <= $urandom_range(0, 15);
					in_valid <= 1'b0;
				end else begin
					in_valid <= 1'b1;
					in_data <= pending_reqs.pop_front();
				end
			end
		end
	end

	// receiver
	int hold_left = 0;
	int recv_rate = 0;
	int beats_taken = 0;
	bit long_hold_done = 1'b0;
	logic [6:0] recv_window = '0;

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			recv_window <= '0;
		end else begin
			recv_window <= recv_window + 1'b1;
			if (recv_window == '0)
				recv_rate <= $urandom_range(0, 3);
			if (out_valid && out_ready)
				beats_taken <= beats_taken + 1;
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (!long_hold_done && beats_taken >= 400) begin
				// hold off long enough for the unit to back up its input
				long_hold_done <= 1'b1;
				hold_left <= LONG_HOLD - 1;
				out_ready <= 1'b0;
			end else if (pending_reqs.size() > TAIL_ITEMS && recv_rate != 0 &&
					$urandom_range(0, 15) < recv_rate) begin
				hold_left <= $urandom_range(0, 15);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("result beat with nothing expected: %h", out_data);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("popped_value", want.popped_value, out_data.popped_value);
				check_field("status", want.status, out_data.status);
				check_field("count", want.count, out_data.count);
				check_field("front_value", want.front_value, out_data.front_value);
				check_field("rear_value", want.rear_value, out_data.rear_value);
			end
		end
	end

	// watchdog on cycles with no beat on either side
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int made;
		int seg_len;
		int push_pct;
		logic [WORD_W-1:0] corner_words[8];

		corner_words = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_F0F0};

		// empty pops, a round trip at both ends, then fill, overflow and pop
		queue_req(FN_POP_FRONT, 32'h1234_5678);
		queue_req(FN_POP_REAR, 32'hFFFF_FFFF);
		queue_req(FN_PUSH_FRONT, 32'h7FFF_FFFF);
		queue_req(FN_PUSH_REAR, 32'h8000_0000);
		queue_req(FN_POP_FRONT, 32'h0);
		queue_req(FN_POP_REAR, 32'h0);
		for (int i = 0; i < DEPTH; i++)
			queue_req(i[0] ? FN_PUSH_REAR : FN_PUSH_FRONT, corner_words[i % 8] ^ i);
		queue_req(FN_PUSH_FRONT, 32'hDEAD_0001);
		queue_req(FN_PUSH_REAR, 32'hDEAD_0002);
		queue_req(FN_POP_FRONT, 32'h0);
		queue_req(FN_POP_REAR, 32'h0);

		// random walk in segments that lean toward filling or draining
		made = 0;
		while (made < RANDOM_ITEMS) begin
			seg_len = $urandom_range(10, 60);
			case ($urandom_range(0, 2))
				0: push_pct = 15;
				1: push_pct = 50;
				default: push_pct = 85;
			endcase
			for (int i = 0; i < seg_len && made < RANDOM_ITEMS; i++) begin
				if ($urandom_range(0, 99) < push_pct)
					queue_req($urandom_range(0, 1) ? FN_PUSH_REAR : FN_PUSH_FRONT,
						pick_word());
				else
					queue_req($urandom_range(0, 1) ? FN_POP_REAR : FN_POP_FRONT,
						pick_word());
				made++;
			end
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		@(posedge clk);
		while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
